/* rtl/flee_pkg.sv */
// Package for the flash EEPROM emulation log core.
// Holds field widths, op codes, the sequencer state type and defaults.
// No dependencies.
`timescale 1ns / 1ps

package flee_pkg;

    localparam int OP_W  = 2;
    localparam int VAL_W = 16;
    localparam int POS_W = 7;

    localparam int                 DEF_SECTOR_BYTES = 512;
    localparam logic [VAL_W-1:0]   DEF_EMPTY_WORD   = 16'hFFFF;

    typedef logic [OP_W-1:0]  op_t;
    typedef logic [VAL_W-1:0] word_t;
    typedef logic [POS_W-1:0] pos_t;

    localparam op_t OP_APPEND = 2'd0;
    localparam op_t OP_RESCAN = 2'd1;
    localparam op_t OP_READ   = 2'd2;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_KEEP_RD,
        ST_KEEP_LATCH,
        ST_ERASE,
        ST_APP_VAL,
        ST_APP_MARK,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_NEW_RD,
        ST_NEW_WAIT,
        ST_DONE
    } state_t;

endpackage

/* rtl/flee_req_if.sv */
// Request channel interface: op code and append value.
// Depends on flee_pkg.
`timescale 1ns / 1ps

interface flee_req_if;
    import flee_pkg::*;

    logic  valid;
    logic  ready;
    op_t   op;
    word_t write_value;

    modport source (output valid, output op, output write_value, input ready);
    modport sink   (input valid, input op, input write_value, output ready);
endinterface

/* rtl/flee_rsp_if.sv */
// Response channel interface: newest value, empty flag, position, erase flag.
// Depends on flee_pkg.
`timescale 1ns / 1ps

interface flee_rsp_if;
    import flee_pkg::*;

    logic  valid;
    logic  ready;
    word_t latest_value;
    logic  is_empty;
    pos_t  position;
    logic  sector_erased;

    modport source (output valid, output latest_value, output is_empty,
                    output position, output sector_erased, input ready);
    modport sink   (input valid, input latest_value, input is_empty,
                    input position, input sector_erased, output ready);
endinterface

/* rtl/flee_ram.sv */
// Generic simple dual-port RAM, one write and one registered read per cycle.
// No dependencies.
`timescale 1ns / 1ps

module flee_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/flash_eeprom_emulation_log_core.sv */
// Top level of the flash EEPROM emulation log: sequencer, slot and index
// counters around one sector RAM. Depends on flee_pkg, flee_req_if,
// flee_rsp_if and flee_ram.
//
//   channel | dir | payload
//   --------+-----+---------------------------------------------------
//   req     | in  | op, write_value
//   rsp     | out | latest_value, is_empty, position, sector_erased
//
// One RAM port pair sets the pace. An append writes the value, then its marker; a
// read fetches the newest value; a rescan reads up to SECTOR_BYTES/4 - 1 markers downward;
// an append with sector erase rewrites the whole sector, one word written per cycle.
// After reset a clearing pass writes the empty word to all SECTOR_BYTES/2
// words, one a cycle; req.ready stays low until it ends.
// A new transaction is taken while a result waits on rsp; the next result
// holds in the sequencer until the output register frees.
`timescale 1ns / 1ps

module flash_eeprom_emulation_log_core #(
    parameter int                        SECTOR_BYTES = flee_pkg::DEF_SECTOR_BYTES,
    parameter logic [flee_pkg::VAL_W-1:0] EMPTY_WORD  = flee_pkg::DEF_EMPTY_WORD
) (
    input  logic           clk,
    input  logic           rst_n,
    flee_req_if.sink       req,
    flee_rsp_if.source     rsp
);
    import flee_pkg::*;

    localparam int SW     = SECTOR_BYTES / 2;
    localparam int HALF   = SW / 2;
    localparam int AW     = $clog2(SW);
    localparam int SLOT_W = $clog2(SW - HALF);

    localparam logic [AW-1:0]     LAST_ADDR = AW'(SW - 1);
    localparam logic [AW-1:0]     PREV_ADDR = AW'(SW - 2);
    localparam logic [AW-1:0]     HALF_ADDR = AW'(HALF);
    localparam logic [AW:0]       SW_EXT    = (AW+1)'(SW);
    localparam logic [SLOT_W-1:0] FULL_SLOT = SLOT_W'(SECTOR_BYTES / 4 - 1);

    state_t              state_reg, state_next;
    op_t                 op_reg, op_next;
    word_t               val_reg, val_next;
    word_t               keep_reg, keep_next;
    word_t               res_val_reg, res_val_next;
    logic                erased_reg, erased_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [AW-1:0]       idx_reg, idx_next;

    logic                out_valid_reg, out_valid_next;
    word_t               out_val_reg, out_val_next;
    logic                out_empty_reg, out_empty_next;
    pos_t                out_pos_reg, out_pos_next;
    logic                out_erased_reg, out_erased_next;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr, ram_raddr;
    word_t               ram_wdata, ram_rdata;

    logic [AW-1:0]       idx_step;
    logic [AW-1:0]       newest_addr;
    logic [AW:0]         mark_full;
    logic                idx_last;
    logic                out_free;
    logic                marker_set;
    word_t               erase_data;

    flee_ram #(
        .WIDTH (VAL_W),
        .DEPTH (SW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // shared index counter: down while scanning markers, up while sweeping
    assign idx_step    = (state_reg == ST_SCAN_CHK) ? idx_reg - 1'b1 : idx_reg + 1'b1;
    assign idx_last    = (idx_reg == LAST_ADDR);
    assign newest_addr = AW'(slot_reg) - 1'b1;
    assign mark_full   = SW_EXT - (AW+1)'(slot_reg);
    assign out_free    = !out_valid_reg || rsp.ready;
    assign marker_set  = (ram_rdata != EMPTY_WORD);

    // sector rebuilt in one sweep: kept value, new value and their two markers
    always_comb
    begin
        if (idx_reg == '0)
        begin
            erase_data = keep_reg;
        end
        else if (idx_reg == AW'(1))
        begin
            erase_data = val_reg;
        end
        else if (idx_reg == LAST_ADDR)
        begin
            erase_data = word_t'(1);
        end
        else if (idx_reg == PREV_ADDR)
        begin
            erase_data = word_t'(2);
        end
        else
        begin
            erase_data = EMPTY_WORD;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (idx_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    case (req.op)
                        OP_APPEND:
                        begin
                            state_next = (slot_reg >= FULL_SLOT) ? ST_KEEP_RD : ST_APP_VAL;
                        end
                        OP_RESCAN:
                        begin
                            state_next = ST_SCAN_RD;
                        end
                        default:
                        begin
                            state_next = ST_NEW_RD;
                        end
                    endcase
                end
            end
            ST_KEEP_RD:    state_next = ST_KEEP_LATCH;
            ST_KEEP_LATCH: state_next = ST_ERASE;
            ST_ERASE:
            begin
                if (idx_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_APP_VAL:    state_next = ST_APP_MARK;
            ST_APP_MARK:   state_next = ST_DONE;
            ST_SCAN_RD:
            begin
                state_next = (idx_reg > HALF_ADDR) ? ST_SCAN_CHK : ST_NEW_RD;
            end
            ST_SCAN_CHK:
            begin
                state_next = marker_set ? ST_SCAN_RD : ST_NEW_RD;
            end
            ST_NEW_RD:
            begin
                state_next = (slot_reg == '0) ? ST_DONE : ST_NEW_WAIT;
            end
            ST_NEW_WAIT:   state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:       state_next = ST_IDLE;
        endcase
    end

    // RAM and handshake controls
    always_comb
    begin
        req.ready = (state_reg == ST_IDLE);
        ram_we    = 1'b0;
        ram_waddr = idx_reg;
        ram_wdata = EMPTY_WORD;
        ram_raddr = newest_addr;
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we = 1'b1;
            end
            ST_ERASE:
            begin
                ram_we    = 1'b1;
                ram_wdata = erase_data;
            end
            ST_APP_VAL:
            begin
                ram_we    = 1'b1;
                ram_waddr = AW'(slot_reg);
                ram_wdata = val_reg;
            end
            ST_APP_MARK:
            begin
                ram_we    = 1'b1;
                ram_waddr = mark_full[AW-1:0];
                ram_wdata = word_t'(slot_reg);
            end
            ST_SCAN_RD:
            begin
                ram_raddr = idx_reg;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // datapath registers
    always_comb
    begin
        op_next         = op_reg;
        val_next        = val_reg;
        keep_next       = keep_reg;
        res_val_next    = res_val_reg;
        erased_next     = erased_reg;
        slot_next       = slot_reg;
        idx_next        = idx_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_val_next    = out_val_reg;
        out_empty_next  = out_empty_reg;
        out_pos_next    = out_pos_reg;
        out_erased_next = out_erased_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                idx_next = idx_step;
            end
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    op_next     = req.op;
                    val_next    = req.write_value;
                    erased_next = 1'b0;
                    if (req.op == OP_RESCAN)
                    begin
                        slot_next = '0;
                        idx_next  = LAST_ADDR;
                    end
                end
            end
            ST_KEEP_LATCH:
            begin
                keep_next = ram_rdata;
                idx_next  = '0;
            end
            ST_ERASE:
            begin
                idx_next = idx_step;
                if (idx_last)
                begin
                    slot_next    = SLOT_W'(2);
                    res_val_next = val_reg;
                    erased_next  = 1'b1;
                end
            end
            ST_APP_VAL:
            begin
                slot_next = slot_reg + 1'b1;
            end
            ST_APP_MARK:
            begin
                res_val_next = val_reg;
            end
            ST_SCAN_CHK:
            begin
                if (marker_set)
                begin
                    slot_next = slot_reg + 1'b1;
                    idx_next  = idx_step;
                end
            end
            ST_NEW_RD:
            begin
                if (slot_reg == '0)
                begin
                    res_val_next = EMPTY_WORD;
                end
            end
            ST_NEW_WAIT:
            begin
                res_val_next = ram_rdata;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_val_next    = res_val_reg;
                    out_empty_next  = (slot_reg == '0);
                    out_pos_next    = POS_W'(slot_reg);
                    out_erased_next = erased_reg && (op_reg == OP_APPEND);
                end
            end
            default:
            begin
                idx_next = idx_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            idx_reg       <= '0;
            slot_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            slot_reg      <= slot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        val_reg        <= val_next;
        keep_reg       <= keep_next;
        res_val_reg    <= res_val_next;
        erased_reg     <= erased_next;
        out_val_reg    <= out_val_next;
        out_empty_reg  <= out_empty_next;
        out_pos_reg    <= out_pos_next;
        out_erased_reg <= out_erased_next;
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.latest_value  = out_val_reg;
    assign rsp.is_empty      = out_empty_reg;
    assign rsp.position      = out_pos_reg;
    assign rsp.sector_erased = out_erased_reg;

endmodule

/* verif/flash_eeprom_emulation_log_core_test.sv */
// Self-checking testbench for flash_eeprom_emulation_log_core.
// Tracks the sector image and write slot in the bench to predict every response.
// Depends on flee_pkg, flee_req_if, flee_rsp_if and the core RTL.
`timescale 1ns / 1ps

module flash_eeprom_emulation_log_core_test;
    import flee_pkg::*;

    localparam int    SECTOR_WORDS = DEF_SECTOR_BYTES / 2;
    localparam int    FULL_SLOT    = DEF_SECTOR_BYTES / 4 - 1;
    localparam word_t EMPTY        = DEF_EMPTY_WORD;
    localparam op_t   OP_UNUSED    = 2'd3;
    localparam int    CYCLE_LIMIT  = 1_000_000;
    // longest path is an erase: one word per cycle across the sector, plus margin
    localparam int    TAIL_CYCLES  = SECTOR_WORDS + 64;

    typedef struct packed {
        word_t latest_value;
        logic  is_empty;
        pos_t  position;
        logic  sector_erased;
    } log_report_t;

    typedef enum {RDY_FREE, RDY_HALF, RDY_SPARSE, RDY_MOSTLY} rdy_mode_t;

    logic clk = 1'b0;
    logic rst_n;

    flee_req_if req_if ();
    flee_rsp_if rsp_if ();

    flash_eeprom_emulation_log_core u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    always #5 clk = ~clk;

    // Bench copy of the flash contents and write slot
    word_t       sector_img [SECTOR_WORDS];
    int unsigned slot_cnt;
    log_report_t pending_reports [$];

    int unsigned fail_count  = 0;
    int unsigned cycle_count = 0;
    int unsigned erase_count = 0;
    int unsigned burst_left  = 0;

    rdy_mode_t   rdy_mode    = RDY_FREE;
    int unsigned rdy_phase   = 0;

    function automatic word_t newest_word();
        if (slot_cnt == 0)
            return EMPTY;
        return sector_img[slot_cnt - 1];
    endfunction

    function automatic log_report_t apply_log_op(op_t op, word_t val);
        log_report_t rep;
        word_t       keep;
        int          idx;
        rep.sector_erased = 1'b0;
        if (op == OP_APPEND) begin
            if (slot_cnt >= FULL_SLOT) begin
                keep = newest_word();
                foreach (sector_img[i])
                    sector_img[i] = EMPTY;
                sector_img[0] = keep;
                sector_img[SECTOR_WORDS - 1] = word_t'(1);
                slot_cnt = 1;
                rep.sector_erased = 1'b1;
            end
            if (slot_cnt < SECTOR_WORDS)
                sector_img[slot_cnt] = val;
            slot_cnt++;
            if (slot_cnt <= SECTOR_WORDS)
                sector_img[SECTOR_WORDS - slot_cnt] = word_t'(slot_cnt);
        end else if (op == OP_RESCAN) begin
            slot_cnt = 0;
            for (idx = SECTOR_WORDS - 1; idx > SECTOR_WORDS / 2; idx--) begin
                if (sector_img[idx] == EMPTY)
                    break;
                slot_cnt++;
            end
        end
        rep.latest_value = newest_word();
        rep.is_empty     = (slot_cnt == 0);
        rep.position     = pos_t'(slot_cnt);
        return rep;
    endfunction

    function automatic word_t random_word();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 16'h0000;
        if (r == 1)
            return EMPTY;
        return word_t'($urandom);
    endfunction

    // Drive one request, wait for acceptance, then queue its prediction.
    task automatic send_item(op_t op, word_t val);
        log_report_t rep;
        @(negedge clk);
        req_if.valid       = 1'b1;
        req_if.op          = op;
        req_if.write_value = val;
        do
            @(posedge clk);
        while (!req_if.ready);
        rep = apply_log_op(op, val);
        if (rep.sector_erased)
            erase_count++;
        pending_reports.push_back(rep);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            @(negedge clk);
            req_if.valid = 1'b0;
            repeat ($urandom_range(0, 5))
                @(negedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 100)
                                                     : $urandom_range(0, 8);
        end
    endtask

    task automatic drain_reports();
        @(negedge clk);
        req_if.valid = 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
    endtask

    // Edge values, every op, reads and rescans on an empty sector.
    task automatic test_directed();
        send_item(OP_READ,   random_word());
        send_item(OP_UNUSED, random_word());
        send_item(OP_RESCAN, random_word());
        send_item(OP_APPEND, 16'h0000);
        send_item(OP_APPEND, 16'hFFFF);
        send_item(OP_READ,   16'h1234);
        send_item(OP_RESCAN, 16'hFFFF);
        send_item(OP_APPEND, 16'h8000);
        send_item(OP_APPEND, 16'h7FFF);
        send_item(OP_APPEND, 16'h5555);
        send_item(OP_APPEND, 16'hAAAA);
        send_item(OP_APPEND, 16'h0001);
        send_item(OP_UNUSED, 16'hFFFF);
        send_item(OP_RESCAN, 16'h0000);
        send_item(OP_READ,   random_word());
        send_item(OP_APPEND, 16'hFFFF);
        send_item(OP_RESCAN, random_word());
        drain_reports();
    endtask

    // Fill the sector through two erase/recover wraps (capped at 400 requests), poking reads
    // and rescans around the full mark and just after recovery.
    task automatic test_fill_and_wrap();
        int unsigned n;
        int unsigned r;
        op_t         op;
        n = 0;
        while (erase_count < 2 && n < 400) begin
            op = OP_APPEND;
            if (slot_cnt >= FULL_SLOT - 3 || slot_cnt <= 3) begin
                r = $urandom_range(0, 7);
                if (r == 0)
                    op = OP_RESCAN;
                else if (r == 1)
                    op = OP_READ;
                else if (r == 2)
                    op = OP_UNUSED;
            end
            send_item(op, random_word());
            n++;
        end
        // rescan and read right after a wrap
        send_item(OP_RESCAN, random_word());
        send_item(OP_READ, random_word());
        drain_reports();
    endtask

    task automatic test_random_mix();
        int unsigned n;
        int unsigned r;
        op_t         op;
        for (n = 0; n < 420; n++) begin
            r = $urandom_range(0, 99);
            if (r < 70)
                op = OP_APPEND;
            else if (r < 80)
                op = OP_RESCAN;
            else if (r < 95)
                op = OP_READ;
            else
                op = OP_UNUSED;
            send_item(op, random_word());
            if (n == 200)
                drain_reports();
        end
        drain_reports();
    endtask

    // Response sink: stall pattern switches mode at random intervals
    always @(negedge clk) begin
        if (rdy_phase == 0) begin
            rdy_mode  = rdy_mode_t'($urandom_range(0, 3));
            rdy_phase = $urandom_range(20, 120);
        end
        rdy_phase--;
        case (rdy_mode)
            RDY_FREE:   rsp_if.ready = 1'b1;
            RDY_HALF:   rsp_if.ready = $urandom_range(0, 1);
            RDY_SPARSE: rsp_if.ready = ($urandom_range(0, 3) == 0);
            default:    rsp_if.ready = ($urandom_range(0, 4) != 0);
        endcase
    end

    always @(posedge clk) begin
        log_report_t want;
        if (rst_n && rsp_if.valid && rsp_if.ready) begin
            if (pending_reports.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("%0t: unexpected rsp transaction: value %h empty %b pos %0d erased %b",
                             $realtime, rsp_if.latest_value, rsp_if.is_empty,
                             rsp_if.position, rsp_if.sector_erased);
            end else begin
                want = pending_reports.pop_front();
                if (rsp_if.latest_value !== want.latest_value || rsp_if.is_empty !== want.is_empty
                    || rsp_if.position !== want.position
                    || rsp_if.sector_erased !== want.sector_erased) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: rsp mismatch: exp %h %b %0d %b, got %h %b %0d %b",
                                 $realtime, want.latest_value, want.is_empty, want.position,
                                 want.sector_erased, rsp_if.latest_value, rsp_if.is_empty,
                                 rsp_if.position, rsp_if.sector_erased);
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        rst_n              = 1'b0;
        req_if.valid       = 1'b0;
        req_if.op          = OP_READ;
        req_if.write_value = '0;
        foreach (sector_img[i])
            sector_img[i] = EMPTY;
        slot_cnt = 0;
        repeat (5)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_fill_and_wrap();
        test_random_mix();

        drain_reports();
        repeat (TAIL_CYCLES)
            @(posedge clk);
        if (fail_count == 0 && pending_reports.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

/* sim.f */
rtl/flee_pkg.sv
rtl/flee_req_if.sv
rtl/flee_rsp_if.sv
rtl/flee_ram.sv
rtl/flash_eeprom_emulation_log_core.sv
verif/flash_eeprom_emulation_log_core_test.sv
